/* hdl/imu_frame_parser_scaler_unit_macros.svh */
`ifndef IMU_FRAME_PARSER_SCALER_UNIT_MACROS_SVH
`define IMU_FRAME_PARSER_SCALER_UNIT_MACROS_SVH

// implication checked in the same cycle
`ifndef SYNTH
`define IMUFPS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("imufps check failed");
`else
`define IMUFPS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`endif

// implication checked in the next cycle
`ifndef SYNTH
`define IMUFPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("imufps check failed");
`else
`define IMUFPS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* hdl/imufps_pkg.sv */
package imufps_pkg;

    localparam logic [7:0] HDR_BYTE = 8'h55;
    localparam logic [7:0] TYPE_LO  = 8'h50;
    localparam logic [7:0] TYPE_HI  = 8'h5A;

    localparam int unsigned PAYLOAD_BYTES = 8;
    localparam int unsigned IDX_W         = $clog2(PAYLOAD_BYTES);
    localparam int unsigned FACTOR_W      = 17;

    localparam logic [3:0] KIND_ACCEL = 4'd1;
    localparam logic [3:0] KIND_RATE  = 4'd2;
    localparam logic [3:0] KIND_ANGLE = 4'd3;
    localparam logic [3:0] KIND_MAG   = 4'd4;
    localparam logic [3:0] KIND_QUAT  = 4'd9;

    // raw * full_scale / 32768 expressed in Q16 units
    localparam logic [FACTOR_W-1:0] FACTOR_ACCEL = 17'd32;
    localparam logic [FACTOR_W-1:0] FACTOR_RATE  = 17'd4000;
    localparam logic [FACTOR_W-1:0] FACTOR_ANGLE = 17'd360;
    localparam logic [FACTOR_W-1:0] FACTOR_MAG   = 17'd65536;
    localparam logic [FACTOR_W-1:0] FACTOR_QUAT  = 17'd2;
    localparam logic [FACTOR_W-1:0] FACTOR_NONE  = 17'd0;

    typedef enum logic [1:0] {
        ST_HUNT,
        ST_KIND,
        ST_PAYLOAD,
        ST_CHECK
    } stage_t;

endpackage

/* hdl/imu_frame_parser_scaler_unit.sv */
// latency: a result is valid in the cycle after its checksum byte transfer
// throughput: one received byte per cycle; rx ready drops only while the
// checksum byte waits behind a result that has not yet been taken
// reset: rst_n clears frame stage, payload index, running sum, kind and the result valid;
// payload and result data registers are not reset
`include "imu_frame_parser_scaler_unit_macros.svh"

module imu_frame_parser_scaler_unit
    import imufps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [3:0]         frame_kind,
    output logic [15:0]        raw_word0,
    output logic [15:0]        raw_word1,
    output logic [15:0]        raw_word2,
    output logic [15:0]        raw_word3,
    output logic signed [31:0] scaled0,
    output logic signed [31:0] scaled1,
    output logic signed [31:0] scaled2,
    output logic signed [31:0] scaled3
);

    stage_t             stage_reg, stage_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [7:0]         sum_reg, sum_next;
    logic [3:0]         kind_reg, kind_next;
    logic [7:0]         payload_reg [PAYLOAD_BYTES];

    logic               out_valid_reg, out_valid_next;
    logic [3:0]         kind_out_reg;
    logic [15:0]        raw_reg    [4];
    logic [31:0]        scaled_reg [4];

    logic               in_xfer;
    logic               type_ok;
    logic               store_en;
    logic               fire;

    logic [15:0]        word      [4];
    logic [FACTOR_W-1:0] factor012;
    logic [FACTOR_W-1:0] factor3;
    logic signed [33:0] prod      [4];

    assign in_xfer = in_valid && in_ready;
    assign in_ready = !(out_valid_reg && !out_ready && stage_reg == ST_CHECK);
    assign type_ok = (rx_byte >= TYPE_LO) && (rx_byte <= TYPE_HI);

    // next stage
    always_comb
    begin
        stage_next = stage_reg;
        idx_next   = idx_reg;
        if (in_xfer)
        begin
            case (stage_reg)
                ST_HUNT:
                begin
                    stage_next = (rx_byte == HDR_BYTE) ? ST_KIND : ST_HUNT;
                end
                ST_KIND:
                begin
                    stage_next = type_ok ? ST_PAYLOAD : ST_HUNT;
                    idx_next   = '0;
                end
                ST_PAYLOAD:
                begin
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == IDX_W'(PAYLOAD_BYTES - 1))
                    begin
                        stage_next = ST_CHECK;
                    end
                end
                ST_CHECK:
                begin
                    stage_next = ST_HUNT;
                end
                default:
                begin
                    stage_next = ST_HUNT;
                end
            endcase
        end
    end

    // stage outputs
    always_comb
    begin
        sum_next  = sum_reg;
        kind_next = kind_reg;
        store_en  = 1'b0;
        fire      = 1'b0;
        if (in_xfer)
        begin
            case (stage_reg)
                ST_HUNT:
                begin
                    sum_next = HDR_BYTE;
                end
                ST_KIND:
                begin
                    if (type_ok)
                    begin
                        sum_next  = sum_reg + rx_byte;
                        kind_next = 4'(rx_byte - TYPE_LO);
                    end
                end
                ST_PAYLOAD:
                begin
                    sum_next = sum_reg + rx_byte;
                    store_en = 1'b1;
                end
                ST_CHECK:
                begin
                    fire = (rx_byte == sum_reg);
                end
                default:
                begin
                    fire = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        factor012 = FACTOR_NONE;
        factor3   = FACTOR_NONE;
        case (kind_reg)
            KIND_ACCEL: factor012 = FACTOR_ACCEL;
            KIND_RATE:  factor012 = FACTOR_RATE;
            KIND_ANGLE: factor012 = FACTOR_ANGLE;
            KIND_MAG:   factor012 = FACTOR_MAG;
            KIND_QUAT:
            begin
                factor012 = FACTOR_QUAT;
                factor3   = FACTOR_QUAT;
            end
            default:    factor012 = FACTOR_NONE;
        endcase
    end

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            word[k] = {payload_reg[2*k+1], payload_reg[2*k]};
        end
        for (int k = 0; k < 3; k++)
        begin
            prod[k] = 34'($signed(word[k])) * 34'($signed({1'b0, factor012}));
        end
        prod[3] = 34'($signed(word[3])) * 34'($signed({1'b0, factor3}));
    end

    assign out_valid_next = (out_valid_reg && !out_ready) || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg     <= ST_HUNT;
            idx_reg       <= '0;
            sum_reg       <= '0;
            kind_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            stage_reg     <= stage_next;
            idx_reg       <= idx_next;
            sum_reg       <= sum_next;
            kind_reg      <= kind_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            payload_reg[idx_reg] <= rx_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            kind_out_reg <= kind_reg;
            for (int k = 0; k < 4; k++)
            begin
                raw_reg[k]    <= word[k];
                scaled_reg[k] <= prod[k][31:0];
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign frame_kind = kind_out_reg;
    assign raw_word0  = raw_reg[0];
    assign raw_word1  = raw_reg[1];
    assign raw_word2  = raw_reg[2];
    assign raw_word3  = raw_reg[3];
    assign scaled0    = scaled_reg[0];
    assign scaled1    = scaled_reg[1];
    assign scaled2    = scaled_reg[2];
    assign scaled3    = scaled_reg[3];

    `IMUFPS_ASSERT_SAME(a_stall_only_on_check, clk, rst_n, !in_ready,
        stage_reg == ST_CHECK && out_valid_reg && !out_ready)
    `IMUFPS_ASSERT_NEXT(a_check_returns_to_hunt, clk, rst_n,
        in_xfer && stage_reg == ST_CHECK, stage_reg == ST_HUNT)
    `IMUFPS_ASSERT_NEXT(a_result_from_check, clk, rst_n,
        !(in_xfer && stage_reg == ST_CHECK) && !(out_valid_reg && !out_ready), !out_valid_reg)
    `IMUFPS_ASSERT_SAME(a_word3_quat_only, clk, rst_n,
        out_valid_reg && scaled_reg[3] != 32'd0, kind_out_reg == KIND_QUAT)

endmodule
